// File: rtl/assert_macros.svh
// Assertion helpers used by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked every cycle outside reset.
`define ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication checked every cycle outside reset.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

// Next-cycle implication that also holds across reset.
`define ASSERT_NEXT_ALWAYS(label, clk, ante, cons, msg) \
   label: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

// File: rtl/ci64_pkg.sv
`timescale 1ns / 1ps
package ci64_pkg;

   localparam int DataWidth = 64;
   localparam int HalfWidth = DataWidth / 2;
   localparam int DivStages = DataWidth;

   localparam logic [2:0] CMD_ADD  = 3'd0;
   localparam logic [2:0] CMD_SUB  = 3'd1;
   localparam logic [2:0] CMD_MUL  = 3'd2;
   localparam logic [2:0] CMD_DIV  = 3'd3;
   localparam logic [2:0] CMD_QUOT = 3'd4;
   localparam logic [2:0] CMD_REM  = 3'd5;

   localparam logic [1:0] ST_OK      = 2'd0;
   localparam logic [1:0] ST_OVF     = 2'd1;
   localparam logic [1:0] ST_DIVZ    = 2'd2;
   localparam logic [1:0] ST_INEXACT = 2'd3;

   typedef struct packed {
      logic [2:0]                  cmd;
      logic signed [DataWidth-1:0] operand_a;
      logic signed [DataWidth-1:0] operand_b;
   } req_type;

   typedef struct packed {
      logic signed [DataWidth-1:0] value;
      logic [1:0]                  status;
   } rsp_type;

endpackage

// File: rtl/checked_int64_arith_unit_core.sv
`timescale 1ns / 1ps
// Channel | Direction | Handshake             | Payload
// req     | in        | req_valid / req_ready | req_data: cmd, operand_a, operand_b
// rsp     | out       | rsp_valid / rsp_ready | rsp_data: value, status
//
// Every transaction passes through stages 1 to 4, the entry register, the 64 one-bit
// restoring divide stages and the output register. One transaction is accepted per
// cycle while the pipeline is not held. Reset clears every valid bit. When a finished
// result is held by a low rsp_ready the whole pipeline holds, and req_ready is low.
module checked_int64_arith_unit_core
   import ci64_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

`include "assert_macros.svh"

   localparam int W = DataWidth;
   localparam int H = HalfWidth;

   // Front stage carrying the operand decode and the simple results.
   typedef struct packed {
      logic [2:0]   cmd;
      logic         sign_a;
      logic         sign_b;
      logic [W-1:0] mag_a;
      logic [W-1:0] mag_b;
      logic         b_zero;
      logic         b_minus_one;
      logic         a_min;
      logic [W-1:0] neg_a;
      logic [W-1:0] as_val;
      logic         as_ovf;
   } front_type;

   // One stage of the divide chain, with the result of the other operations riding along.
   typedef struct packed {
      logic [2:0]   cmd;
      logic         neg_q;
      logic         neg_r;
      logic         early_done;
      logic [W-1:0] early_val;
      logic [1:0]   early_st;
      logic [W-1:0] dvsr;
      logic [W-1:0] rem;
      logic [W-1:0] quo;
   } div_stage_type;

   localparam logic [W-1:0] SignBit = {1'b1, {(W-1){1'b0}}};

   // The pipeline advances as one unit whenever the output register can take a result.
   logic advance;
   assign advance   = !rsp_valid || rsp_ready;
   assign req_ready = advance;

   // Stage 1: input register.
   logic    s1_valid_ff;
   req_type s1_ff;

   // Stage 2: magnitudes, add and subtract.
   logic      s2_valid_ff;
   front_type s2_ff, s2_in;

   // Stage 3: four half-width partial products.
   logic         s3_valid_ff;
   front_type    s3_ff;
   logic [W-1:0] pp_ll_ff, pp_lh_ff, pp_hl_ff, pp_hh_ff;

   // Stage 4: full product as hi:lo.
   logic         s4_valid_ff;
   front_type    s4_ff;
   logic [W-1:0] prod_hi_ff, prod_lo_ff, prod_hi_in, prod_lo_in;

   logic [W-1:0] ua, ub, add_r, sub_r;
   always_comb begin
      ua    = s1_ff.operand_a;
      ub    = s1_ff.operand_b;
      add_r = ua + ub;
      sub_r = ua - ub;
      s2_in.cmd         = s1_ff.cmd;
      s2_in.sign_a      = ua[W-1];
      s2_in.sign_b      = ub[W-1];
      s2_in.mag_a       = ua[W-1] ? (~ua + 1'b1) : ua;
      s2_in.mag_b       = ub[W-1] ? (~ub + 1'b1) : ub;
      s2_in.b_zero      = (ub == '0);
      s2_in.b_minus_one = (ub == '1);
      s2_in.a_min       = (ua == SignBit);
      s2_in.neg_a       = ~ua + 1'b1;
      if (s1_ff.cmd == CMD_ADD) begin
         s2_in.as_val = add_r;
         s2_in.as_ovf = ((ua ^ add_r) & (ub ^ add_r) & SignBit) != '0;
      end else begin
         s2_in.as_val = sub_r;
         s2_in.as_ovf = ((ua ^ ub) & (ua ^ sub_r) & SignBit) != '0;
      end
   end

   logic [W-1:0] mid;
   always_comb begin
      mid = {{H{1'b0}}, pp_ll_ff[W-1:H]} + {{H{1'b0}}, pp_lh_ff[H-1:0]}
          + {{H{1'b0}}, pp_hl_ff[H-1:0]};
      prod_lo_in = {mid[H-1:0], pp_ll_ff[H-1:0]};
      prod_hi_in = pp_hh_ff + {{H{1'b0}}, pp_lh_ff[W-1:H]}
                 + {{H{1'b0}}, pp_hl_ff[W-1:H]} + {{H{1'b0}}, mid[W-1:H]};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
         s4_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff <= req_valid;
         s2_valid_ff <= s1_valid_ff;
         s3_valid_ff <= s2_valid_ff;
         s4_valid_ff <= s3_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_ff      <= req_data;
         s2_ff      <= s2_in;
         s3_ff      <= s2_ff;
         pp_ll_ff   <= s2_ff.mag_a[H-1:0] * s2_ff.mag_b[H-1:0];
         pp_lh_ff   <= s2_ff.mag_a[H-1:0] * s2_ff.mag_b[W-1:H];
         pp_hl_ff   <= s2_ff.mag_a[W-1:H] * s2_ff.mag_b[H-1:0];
         pp_hh_ff   <= s2_ff.mag_a[W-1:H] * s2_ff.mag_b[W-1:H];
         s4_ff      <= s3_ff;
         prod_hi_ff <= prod_hi_in;
         prod_lo_ff <= prod_lo_in;
      end
   end

   // Decide multiply overflow and every special case before the divide chain.
   div_stage_type dv_entry;
   logic          mul_neg, mul_ovf;
   always_comb begin
      mul_neg = s4_ff.sign_a ^ s4_ff.sign_b;
      mul_ovf = (prod_hi_ff != '0)
             || (prod_lo_ff > (mul_neg ? SignBit : SignBit - 1'b1));
      dv_entry.cmd        = s4_ff.cmd;
      dv_entry.neg_q      = mul_neg;
      dv_entry.neg_r      = s4_ff.sign_a;
      dv_entry.early_done = 1'b1;
      dv_entry.early_val  = '0;
      dv_entry.early_st   = ST_OK;
      dv_entry.dvsr       = s4_ff.mag_b;
      dv_entry.rem        = '0;
      dv_entry.quo        = s4_ff.mag_a;
      case (s4_ff.cmd)
         CMD_ADD, CMD_SUB: begin
            if (s4_ff.as_ovf) dv_entry.early_st = ST_OVF;
            else dv_entry.early_val = s4_ff.as_val;
         end
         CMD_MUL: begin
            if (mul_ovf) dv_entry.early_st = ST_OVF;
            else dv_entry.early_val = mul_neg ? (~prod_lo_ff + 1'b1) : prod_lo_ff;
         end
         CMD_DIV, CMD_QUOT, CMD_REM: begin
            if (s4_ff.b_zero) begin
               dv_entry.early_st = ST_DIVZ;
            end else if (s4_ff.b_minus_one) begin
               // A divisor of minus one negates; the remainder is then zero.
               if (s4_ff.cmd != CMD_REM) begin
                  if (s4_ff.a_min) dv_entry.early_st = ST_OVF;
                  else dv_entry.early_val = s4_ff.neg_a;
               end
            end else begin
               dv_entry.early_done = 1'b0;
            end
         end
         default: begin
         end
      endcase
   end

   // Restoring divide, one quotient bit per stage.
   logic          dv_valid_ff [DivStages+1];
   div_stage_type dv_ff       [DivStages+1];

   always_ff @(posedge clock) begin
      if (reset) begin
         dv_valid_ff[0] <= 1'b0;
      end else if (advance) begin
         dv_valid_ff[0] <= s4_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) dv_ff[0] <= dv_entry;
   end

   genvar gi;
   generate
      for (gi = 0; gi < DivStages; gi++) begin : g_div
         div_stage_type dv_in;
         logic [W-1:0]  trial;
         logic          fits;
         always_comb begin
            trial = {dv_ff[gi].rem[W-2:0], dv_ff[gi].quo[W-1]};
            fits  = (trial >= dv_ff[gi].dvsr);
            dv_in      = dv_ff[gi];
            dv_in.rem  = fits ? (trial - dv_ff[gi].dvsr) : trial;
            dv_in.quo  = {dv_ff[gi].quo[W-2:0], fits};
         end
         always_ff @(posedge clock) begin
            if (reset) begin
               dv_valid_ff[gi+1] <= 1'b0;
            end else if (advance) begin
               dv_valid_ff[gi+1] <= dv_valid_ff[gi];
            end
         end
         always_ff @(posedge clock) begin
            if (advance) dv_ff[gi+1] <= dv_in;
         end
      end
   endgenerate

   // Final stage: apply the signs and pick the result.
   div_stage_type dv_last;
   logic [W-1:0]  q_signed, r_signed;
   rsp_type       rsp_in, rsp_ff;
   logic          rsp_valid_ff;
   always_comb begin
      dv_last  = dv_ff[DivStages];
      q_signed = dv_last.neg_q ? (~dv_last.quo + 1'b1) : dv_last.quo;
      r_signed = dv_last.neg_r ? (~dv_last.rem + 1'b1) : dv_last.rem;
      rsp_in.value  = dv_last.early_val;
      rsp_in.status = dv_last.early_st;
      if (!dv_last.early_done) begin
         case (dv_last.cmd)
            CMD_DIV: begin
               if (dv_last.rem != '0) begin
                  rsp_in.value  = '0;
                  rsp_in.status = ST_INEXACT;
               end else begin
                  rsp_in.value = q_signed;
               end
            end
            CMD_QUOT: rsp_in.value = q_signed;
            CMD_REM:  rsp_in.value = r_signed;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= dv_valid_ff[DivStages];
      end
   end

   always_ff @(posedge clock) begin
      if (advance) rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // Any error status must come with a zero value.
   `ASSERT_IMPL(a_err_zero, clock, reset, rsp_valid_ff && (rsp_ff.status != ST_OK), rsp_ff.value == '0, "error result with nonzero value")
   // A held pipeline keeps its front stage untouched.
   `ASSERT_NEXT(a_hold_front, clock, reset, !advance, $stable(s1_ff) && $stable(s1_valid_ff), "front stage moved during stall")
   // Reset leaves no result pending.
   `ASSERT_NEXT_ALWAYS(a_reset_empty, clock, reset, !rsp_valid_ff, "result valid after reset")
   // Only division commands can reach the last stage without an early result.
   `ASSERT_IMPL(a_div_only, clock, reset, dv_valid_ff[DivStages] && !dv_last.early_done, (dv_last.cmd == CMD_DIV) || (dv_last.cmd == CMD_QUOT) || (dv_last.cmd == CMD_REM), "non-division item took the divide path")

endmodule

// File: sim/checked_int64_arith_unit_core_tb.sv
`timescale 1ns / 1ps
// Testbench for the checked 64-bit integer arithmetic unit.
// Every accepted request transaction is run through a local prediction of the
// checked arithmetic and the expected response is queued. A separate process
// compares each accepted response transaction, field by field, with the oldest
// queued expectation. The block returns responses in request order, so the
// expectation queue is all the ordering information that is needed.
module checked_int64_arith_unit_core_tb;
   import ci64_pkg::*;

   localparam int Latency    = DataWidth + 5;
   localparam int CycleLimit = 400000;

   localparam logic signed [63:0] MinVal = 64'sh8000000000000000;
   localparam logic signed [63:0] MaxVal = 64'sh7fffffffffffffff;
   localparam logic signed [63:0] NegOne = -64'sd1;

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_ready;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_ready;
   rsp_type rsp_data;

   rsp_type expected_rsps[$];
   int      error_count;
   int      cycle_count;
   bit      long_stall_request;
   bit      long_stall_active;

   checked_int64_arith_unit_core dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   always begin
      clock = 1'b0;
      #1;
      clock = 1'b1;
      #1;
   end

   // Checked arithmetic prediction. Add and subtract use a 65-bit sum, and
   // multiply uses the full 128-bit signed product, so overflow is simply a
   // result that does not fit back into 64 signed bits.
   function automatic rsp_type predict_checked_op(req_type r);
      rsp_type                res;
      logic signed [64:0]     wide_sum;
      logic signed [127:0]    wide_prod;
      logic signed [63:0]     a;
      logic signed [63:0]     b;
      a = r.operand_a;
      b = r.operand_b;
      res.value  = '0;
      res.status = ST_OK;
      case (r.cmd)
         CMD_ADD: begin
            wide_sum = 65'(a) + 65'(b);
            if (wide_sum[64] != wide_sum[63]) res.status = ST_OVF;
            else res.value = wide_sum[63:0];
         end
         CMD_SUB: begin
            wide_sum = 65'(a) - 65'(b);
            if (wide_sum[64] != wide_sum[63]) res.status = ST_OVF;
            else res.value = wide_sum[63:0];
         end
         CMD_MUL: begin
            wide_prod = 128'(a) * 128'(b);
            if (wide_prod[127:63] != {65{wide_prod[63]}}) res.status = ST_OVF;
            else res.value = wide_prod[63:0];
         end
         CMD_DIV, CMD_QUOT: begin
            // A divisor of minus one is handled apart so that the minimum
            // dividend never reaches the simulator's own division.
            if (b == 0) res.status = ST_DIVZ;
            else if (b == NegOne) begin
               if (a == MinVal) res.status = ST_OVF;
               else res.value = -a;
            end else if (r.cmd == CMD_DIV && (a % b) != 0) res.status = ST_INEXACT;
            else res.value = a / b;
         end
         CMD_REM: begin
            if (b == 0) res.status = ST_DIVZ;
            else if (b != NegOne) res.value = a % b;
         end
         default: ;
      endcase
      return res;
   endfunction

   // Sender side: one transaction offered and held until accepted.
   task automatic send_op(input logic [2:0] cmd, input logic [63:0] a,
                          input logic [63:0] b);
      req_type r;
      r.cmd       = cmd;
      r.operand_a = a;
      r.operand_b = b;
      req_valid <= 1'b1;
      req_data  <= r;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      expected_rsps.push_back(predict_checked_op(r));
   endtask

   task automatic idle_cycles(input int n);
      if (n > 0) begin
         req_valid <= 1'b0;
         repeat (n) @(posedge clock);
      end
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (expected_rsps.size() != 0) @(posedge clock);
   endtask

   // Operand generator biased toward the corners: zero, one, minus one, the
   // extremes, small values, zero- or ones-topped 32-bit values and random patterns.
   function automatic logic [63:0] pick_operand();
      case ($urandom_range(0, 9))
         0: return 64'd0;
         1: return 64'd1;
         2: return NegOne;
         3: return MinVal;
         4: return MaxVal;
         5: return 64'($signed($urandom_range(0, 200)) - 100);
         6: return {{32{$urandom_range(0, 1) == 1}}, 32'($urandom)};
         default: return {32'($urandom), 32'($urandom)};
      endcase
   endfunction

   task automatic send_random_op();
      logic [2:0]  cmd;
      logic [63:0] a;
      logic [63:0] b;
      cmd = 3'($urandom_range(0, 7));
      if (cmd > CMD_REM && $urandom_range(0, 3) != 0)
         cmd = 3'($urandom_range(0, 5));
      a = pick_operand();
      b = pick_operand();
      // Build exact divisions often enough that the ok path of divide is hit.
      if (cmd == CMD_DIV && $urandom_range(0, 1) == 1) begin
         b = 64'($signed($urandom_range(1, 1000)) - 500);
         if (b == 0) b = 64'd3;
         a = 64'($signed(b) * ($signed({32'd0, 32'($urandom)}) - 64'sd2147483648));
      end
      send_op(cmd, a, b);
   endtask

   task automatic test_add_sub_extremes();
      send_op(CMD_ADD, MaxVal, 64'd1);
      send_op(CMD_ADD, MinVal, NegOne);
      send_op(CMD_ADD, MaxVal, MinVal);
      send_op(CMD_ADD, 64'd0, 64'd0);
      send_op(CMD_SUB, MinVal, 64'd1);
      send_op(CMD_SUB, 64'd0, MinVal);
      send_op(CMD_SUB, NegOne, MinVal);
      send_op(CMD_SUB, MaxVal, MaxVal);
   endtask

   task automatic test_multiply_extremes();
      send_op(CMD_MUL, MinVal, 64'd1);
      send_op(CMD_MUL, MinVal, NegOne);
      send_op(CMD_MUL, MaxVal, NegOne);
      send_op(CMD_MUL, 64'h0000000100000000, 64'hffffffff80000000);
      send_op(CMD_MUL, 64'h0000000100000000, 64'h0000000080000000);
      send_op(CMD_MUL, MaxVal, MaxVal);
   endtask

   task automatic test_division_cases();
      send_op(CMD_DIV, 64'd7, 64'd0);
      send_op(CMD_QUOT, MinVal, 64'd0);
      send_op(CMD_REM, MaxVal, 64'd0);
      send_op(CMD_DIV, MinVal, NegOne);
      send_op(CMD_QUOT, MinVal, NegOne);
      send_op(CMD_QUOT, MaxVal, NegOne);
      send_op(CMD_REM, MinVal, NegOne);
      send_op(CMD_DIV, 64'd7, 64'd2);
      send_op(CMD_DIV, -64'sd12, 64'd3);
      send_op(CMD_QUOT, -64'sd7, 64'd2);
      send_op(CMD_REM, -64'sd7, 64'd2);
      send_op(CMD_REM, 64'd7, -64'sd2);
      send_op(3'd6, MaxVal, MaxVal);
      send_op(3'd7, MinVal, NegOne);
   endtask

   // Random traffic sent in bursts of random length with random gaps.
   task automatic test_random_bursts(input int n);
      int sent;
      sent = 0;
      while (sent < n) begin
         repeat ($urandom_range(1, 30)) begin
            if (sent < n) begin
               send_random_op();
               sent++;
            end
         end
         if ($urandom_range(0, 2) != 0) idle_cycles($urandom_range(1, 8));
      end
   endtask

   // The receiver holds off long enough for the pipeline to fill while the
   // sender keeps offering transactions back to back.
   task automatic test_backpressure();
      long_stall_request = 1'b1;
      repeat (200) send_random_op();
      long_stall_request = 1'b0;
   endtask

   // Receiver: a long hold-off when asked, otherwise stalls in random runs
   // with stretches of no stalling at all.
   initial begin
      int run;
      rsp_ready         <= 1'b0;
      long_stall_active = 1'b0;
      @(posedge clock);
      forever begin
         if (long_stall_request && !long_stall_active) begin
            long_stall_active = 1'b1;
            rsp_ready <= 1'b0;
            repeat (3 * Latency) @(posedge clock);
         end else begin
            run = $urandom_range(1, 40);
            case ($urandom_range(0, 3))
               0: rsp_ready <= 1'b0;
               1: rsp_ready <= 1'b1;
               default: rsp_ready <= ($urandom_range(0, 2) != 0);
            endcase
            if (!long_stall_request) long_stall_active = 1'b0;
            repeat ((run > 4) ? 4 : run) @(posedge clock);
         end
      end
   end

   // Response checker.
   always @(posedge clock) begin
      rsp_type exp_rsp;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_rsps.size() == 0) begin
            $display("%0t: unexpected response transaction value=%0d status=%0d",
                     $time, rsp_data.value, rsp_data.status);
            error_count++;
         end else begin
            exp_rsp = expected_rsps.pop_front();
            if (rsp_data.value !== exp_rsp.value) begin
               $display("%0t: value mismatch, expected %0d, actual %0d",
                        $time, exp_rsp.value, rsp_data.value);
               error_count++;
            end
            if (rsp_data.status !== exp_rsp.status) begin
               $display("%0t: status mismatch, expected %0d, actual %0d",
                        $time, exp_rsp.status, rsp_data.status);
               error_count++;
            end
         end
      end
   end

   // Watchdog on the total run length.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CycleLimit) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   initial begin
      error_count        = 0;
      cycle_count        = 0;
      long_stall_request = 1'b0;
      reset     <= 1'b1;
      req_valid <= 1'b0;
      req_data  <= '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_add_sub_extremes();
      test_multiply_extremes();
      test_division_cases();
      // Sender pauses here until every outstanding result has come back.
      wait_drained();
      test_random_bursts(500);
      test_backpressure();
      test_random_bursts(520);

      wait_drained();
      repeat (2 * Latency) @(posedge clock);
      if (error_count == 0 && expected_rsps.size() == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
